FILE: rtl/core/swpm_pkg.sv
package swpm_pkg;

   localparam int INDEX_BITS = 6;
   localparam int VALUE_BITS = 16;
   localparam int LEN_BITS   = 5;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_MEDIAN = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW_LEN = 1'b0;

   typedef struct packed {
      logic push;
      logic start;
      logic load;
      logic read;
      logic shift;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic reads_done;
      logic shifts_done;
      logic out_taken;
      logic out_last;
   } dp_status_type;

endpackage

FILE: rtl/core/swpm_ctrl.sv
module swpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_op,
   output logic                   req_stall,
   input  swpm_pkg::dp_status_type st,
   output swpm_pkg::dp_cmd_type    cmd
);
   import swpm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = st.empty ? ST_EMIT : ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            // the last read's data is sorted in while this state sees reads_done
            if (st.reads_done) state_in = ST_SHIFT;
            else cmd.read = 1'b1;
         end
         ST_SHIFT: begin
            if (st.shifts_done) state_in = ST_EMIT;
            else cmd.shift = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (st.out_taken) begin
               if (st.out_last) state_in = ST_IDLE;
               else state_in = st.empty ? ST_EMIT : ST_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: rtl/core/swpm_dp.sv
module swpm_dp #(
   parameter int GRID_SIDE  = 8,
   parameter int WINDOW_MAX = 16,
   parameter int PIXEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  swpm_pkg::dp_cmd_type               cmd,
   output swpm_pkg::dp_status_type            st,
   input  logic [swpm_pkg::INDEX_BITS-1:0]    req_pixel_index,
   input  logic [swpm_pkg::VALUE_BITS-1:0]    req_pixel_value,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [swpm_pkg::VALUE_BITS-1:0]    rsp_median_value,
   output logic [swpm_pkg::INDEX_BITS-1:0]    rsp_out_index,
   output logic                               rsp_last_pixel,
   output logic                               rsp_window_empty,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swpm_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [swpm_pkg::DATA_BITS-1:0]     pwdata,
   output logic [swpm_pkg::DATA_BITS-1:0]     prdata
);
   import swpm_pkg::*;

   localparam int NPIX      = GRID_SIDE * GRID_SIDE;
   localparam int NSLOT     = WINDOW_MAX + 1;
   localparam int PB        = $clog2(NPIX);
   localparam int SW        = $clog2(NSLOT);
   localparam int CW        = $clog2(WINDOW_MAX + 1);
   localparam int GW        = $clog2(GRID_SIDE);
   localparam int IW        = (PB > INDEX_BITS) ? PB : INDEX_BITS;
   localparam int AW        = SW + PB;
   localparam int DEPTH     = NSLOT * (2 ** PB);
   localparam int LEN_RESET = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;
   localparam int C1        = (WINDOW_MAX > 1) ? 1 : 0;

   logic [PIXEL_BITS-1:0] mem [DEPTH];
   logic [PIXEL_BITS-1:0] mem_q;

   logic [CW-1:0] window_len_ff, window_len_in;
   logic [CW-1:0] frame_count_ff, frame_count_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic [SW-1:0] spare;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0] shift_cnt_ff, shift_cnt_in;
   logic [CW-1:0] shift_target;
   logic          rd_vld_ff;
   logic [GW-1:0] row_ff, row_in, col_ff, col_in;
   logic [PB-1:0] pix_cur;
   logic [IW-1:0] pix_cur_w;
   logic [IW-1:0] pix_req_w;
   logic          pix_ok;
   logic          cfg_wr;
   logic [LEN_BITS:0] len_wr;
   logic          at_last;

   logic [PIXEL_BITS-1:0] sort_ff [WINDOW_MAX];
   logic [PIXEL_BITS-1:0] sort_in [WINDOW_MAX];
   logic [PIXEL_BITS:0]   pair_sum;
   logic [PIXEL_BITS-1:0] median;

   logic                  out_valid_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic [INDEX_BITS-1:0] out_index_ff;
   logic                  out_last_ff;
   logic                  out_empty_ff;

   // configuration
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
   assign len_wr = {1'b0, pwdata[LEN_BITS-1:0]};
   assign prdata = (paddr[2] == REG_WINDOW_LEN) ? DATA_BITS'(window_len_ff) : '0;

   always_comb begin
      window_len_in = window_len_ff;
      if (cfg_wr) begin
         if (len_wr == '0) window_len_in = CW'(1);
         else if (len_wr > (LEN_BITS+1)'(WINDOW_MAX)) window_len_in = CW'(WINDOW_MAX);
         else window_len_in = CW'(len_wr);
      end
   end

   // ring of frame slots
   assign spare     = (newest_ff == SW'(NSLOT - 1)) ? '0 : newest_ff + SW'(1);
   assign pix_req_w = IW'(req_pixel_index);
   assign pix_ok    = (32'(pix_req_w) < 32'(NPIX));

   always_comb begin
      newest_in      = newest_ff;
      frame_count_in = frame_count_ff;
      if (cfg_wr) begin
         frame_count_in = '0;
      end else if (cmd.push && req_frame_end) begin
         newest_in = spare;
         if (frame_count_ff < window_len_ff) frame_count_in = frame_count_ff + CW'(1);
         else frame_count_in = window_len_ff;
      end
   end

   // scan position, column by column
   assign pix_cur   = PB'(int'(row_ff) * GRID_SIDE + int'(col_ff));
   assign pix_cur_w = IW'(pix_cur);
   assign at_last   = (row_ff == GW'(GRID_SIDE - 1)) && (col_ff == GW'(GRID_SIDE - 1));

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.start) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.emit) begin
         if (row_ff == GW'(GRID_SIDE - 1)) begin
            row_in = '0;
            col_in = col_ff + GW'(1);
         end else begin
            row_in = row_ff + GW'(1);
         end
      end
   end

   // read walk, newest frame backwards
   always_comb begin
      rd_slot_in   = rd_slot_ff;
      rd_cnt_in    = rd_cnt_ff;
      shift_cnt_in = shift_cnt_ff;
      if (cmd.load) begin
         rd_slot_in   = newest_ff;
         rd_cnt_in    = '0;
         shift_cnt_in = '0;
      end else if (cmd.read) begin
         rd_slot_in = (rd_slot_ff == '0) ? SW'(NSLOT - 1) : rd_slot_ff - SW'(1);
         rd_cnt_in  = rd_cnt_ff + CW'(1);
      end else if (cmd.shift) begin
         shift_cnt_in = shift_cnt_ff + CW'(1);
      end
   end

   assign shift_target = (frame_count_ff - CW'(1)) >> 1;

   always_ff @(posedge clock) begin
      if (cmd.push && pix_ok) mem[{spare, pix_req_w[PB-1:0]}] <= req_pixel_value[PIXEL_BITS-1:0];
      if (cmd.read) mem_q <= mem[{rd_slot_ff, pix_cur}];
   end

   // insertion sorter: empty cells hold all ones
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         sort_in[i] = sort_ff[i];
         if (cmd.load) begin
            sort_in[i] = '1;
         end else if (rd_vld_ff) begin
            if (sort_ff[i] > mem_q) begin
               if (i == 0) sort_in[i] = mem_q;
               else if (sort_ff[(i == 0) ? 0 : i - 1] <= mem_q) sort_in[i] = mem_q;
               else sort_in[i] = sort_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.shift) begin
            // drop the lowest, move the middle down towards cell 0
            if (i == WINDOW_MAX - 1) sort_in[i] = '1;
            else sort_in[i] = sort_ff[(i == WINDOW_MAX - 1) ? i : i + 1];
         end
      end
   end

   assign pair_sum = {1'b0, sort_ff[0]} + {1'b0, sort_ff[C1]};
   assign median   = frame_count_ff[0] ? sort_ff[0] : pair_sum[PIXEL_BITS:1];

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_MAX; i++) sort_ff[i] <= sort_in[i];
      shift_cnt_ff <= shift_cnt_in;
      rd_cnt_ff    <= rd_cnt_in;
      rd_slot_ff   <= rd_slot_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      if (cmd.emit) begin
         out_value_ff <= st.empty ? '0 : VALUE_BITS'(median);
         out_index_ff <= pix_cur_w[INDEX_BITS-1:0];
         out_last_ff  <= at_last;
         out_empty_ff <= st.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= CW'(LEN_RESET);
         frame_count_ff <= '0;
         newest_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         window_len_ff  <= window_len_in;
         frame_count_ff <= frame_count_in;
         newest_ff      <= newest_in;
         rd_vld_ff      <= cmd.read;
         if (cmd.emit) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   assign st.empty       = (frame_count_ff == '0);
   assign st.reads_done  = (rd_cnt_ff == frame_count_ff);
   assign st.shifts_done = (shift_cnt_ff == shift_target);
   assign st.out_taken   = out_valid_ff && !rsp_stall;
   assign st.out_last    = out_last_ff;

   assign rsp_valid        = out_valid_ff;
   assign rsp_median_value = out_value_ff;
   assign rsp_out_index    = out_index_ff;
   assign rsp_last_pixel   = out_last_ff;
   assign rsp_window_empty = out_empty_ff;

endmodule

FILE: rtl/core/sliding_window_pixel_median.sv
// channel   direction  handshake          payload
// req_      in         req_valid/stall    op, pixel_index, pixel_value, frame_end
// rsp_      out        rsp_valid/stall    median_value, out_index, last_pixel, window_empty
// apb       in         psel/penable       window_len at byte address 0
//
// A push does not raise req_stall. A median request gives GRID_SIDE^2 results;
// the time for each pixel is set by one read of the frame memory per frame held
// and the shift-down of the insertion sorter.
// With an empty window the reads and the sort are skipped.
// Reset is synchronous; the frame memory is not cleared.
// req_stall is high for the whole of a median request; a stalled result holds the scan.
module sliding_window_pixel_median #(
   parameter int GRID_SIDE  = 8,
   parameter int WINDOW_MAX = 16,
   parameter int PIXEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [swpm_pkg::INDEX_BITS-1:0]    req_pixel_index,
   input  logic [swpm_pkg::VALUE_BITS-1:0]    req_pixel_value,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [swpm_pkg::VALUE_BITS-1:0]    rsp_median_value,
   output logic [swpm_pkg::INDEX_BITS-1:0]    rsp_out_index,
   output logic                               rsp_last_pixel,
   output logic                               rsp_window_empty,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swpm_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [swpm_pkg::DATA_BITS-1:0]     pwdata,
   output logic [swpm_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);
   import swpm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   assign pready = 1'b1;

   swpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   swpm_dp #(
      .GRID_SIDE  (GRID_SIDE),
      .WINDOW_MAX (WINDOW_MAX),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_value  (req_pixel_value),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .rsp_out_index    (rsp_out_index),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_window_empty (rsp_window_empty),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata)
   );

endmodule

FILE: tb/sliding_window_pixel_median_tb.sv
`timescale 1ns / 1ps

module sliding_window_pixel_median_tb;
   import swpm_pkg::*;

   localparam int SIDE    = 8;
   localparam int NPIX    = SIDE * SIDE;
   localparam int WMAX    = 16;
   localparam int NSLOT   = WMAX + 1;
   localparam int LIMIT   = 3000000;
   localparam logic [ADDR_BITS-1:0] ADDR_WINDOW_LEN = 3'd0;
   localparam logic [ADDR_BITS-1:0] ADDR_UNUSED     = 3'd4;

   typedef struct packed {
      logic [VALUE_BITS-1:0] median;
      logic [INDEX_BITS-1:0] index;
      logic                  last;
      logic                  empty;
   } median_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = OP_PUSH;
   logic [INDEX_BITS-1:0] req_pixel_index = '0;
   logic [VALUE_BITS-1:0] req_pixel_value = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_median_value;
   logic [INDEX_BITS-1:0] rsp_out_index;
   logic                  rsp_last_pixel;
   logic                  rsp_window_empty;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  paddr = '0;
   logic [DATA_BITS-1:0]  pwdata = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   sliding_window_pixel_median dut (.*);

   // predictor state
   logic [VALUE_BITS-1:0] frames [NSLOT][NPIX];
   bit                    filled [NSLOT][NPIX];
   int                    win_len = WMAX;
   int                    frames_held = 0;
   int                    newest = 0;

   median_result_t        medians_due[$];
   int                    mismatches = 0;
   int                    cycles = 0;
   bit                    quiet = 1'b0;
   bit                    hold_go = 1'b0;
   int                    hold_len = 0;
   int                    hold_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[sliding_window_pixel_median] ERROR");
         $finish;
      end
   end

   // receiver: random stall, or a long counted hold-off
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= (!quiet && $urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      median_result_t got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_median_value, rsp_out_index, rsp_last_pixel, rsp_window_empty};
         if (medians_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: got %h", got);
         end else begin
            want = medians_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want med=%0d idx=%0d last=%b empty=%b, %s",
                     want.median, want.index, want.last, want.empty,
                     $sformatf("got med=%0d idx=%0d last=%b empty=%b",
                        got.median, got.index, got.last, got.empty));
            end
         end
      end
   end

   function automatic logic [VALUE_BITS-1:0] pixel_median(int pix);
      int vals[WMAX];
      int n, slot, t;
      n = frames_held;
      slot = newest;
      for (int k = 0; k < n; k++) begin
         vals[k] = frames[slot][pix];
         slot = (slot == 0) ? NSLOT - 1 : slot - 1;
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j + 1 < n - i; j++)
            if (vals[j] > vals[j+1]) begin
               t = vals[j]; vals[j] = vals[j+1]; vals[j+1] = t;
            end
      if (n % 2 == 1) return VALUE_BITS'(vals[n/2]);
      return VALUE_BITS'((vals[n/2-1] + vals[n/2]) / 2);
   endfunction

   function automatic bit query_is_safe();
      int slot;
      slot = newest;
      for (int k = 0; k < frames_held; k++) begin
         for (int p = 0; p < NPIX; p++)
            if (!filled[slot][p]) return 1'b0;
         slot = (slot == 0) ? NSLOT - 1 : slot - 1;
      end
      return 1'b1;
   endfunction

   function automatic void apply_request(logic op, int idx, logic [15:0] val, logic fe);
      int spare, k;
      median_result_t r;
      if (op == OP_PUSH) begin
         spare = (newest + 1) % NSLOT;
         frames[spare][idx] = val;
         filled[spare][idx] = 1'b1;
         if (fe) begin
            newest = spare;
            if (frames_held < win_len) frames_held++;
         end
      end else begin
         k = 0;
         for (int c = 0; c < SIDE; c++)
            for (int rw = 0; rw < SIDE; rw++) begin
               r.index  = INDEX_BITS'(rw * SIDE + c);
               r.empty  = (frames_held == 0);
               r.median = r.empty ? '0 : pixel_median(rw * SIDE + c);
               r.last   = (k == NPIX - 1);
               medians_due.push_back(r);
               k++;
            end
      end
   endfunction

   task automatic send(logic op, int idx, logic [15:0] val, logic fe);
      if (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_index <= INDEX_BITS'(idx);
      req_pixel_value <= val;
      req_frame_end <= fe;
      do @(posedge clock); while (req_stall);
      apply_request(op, idx, val, fe);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (medians_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_WINDOW_LEN) begin
         win_len = data[4:0];
         if (win_len < 1) win_len = 1;
         if (win_len > WMAX) win_len = WMAX;
         frames_held = 0;
      end
   endtask

   task automatic csr_check(logic [ADDR_BITS-1:0] addr, logic [31:0] want);
      logic [31:0] got;
      psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel <= 1'b0; penable <= 1'b0;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register read: want %0d, got %0d", want, got);
      end
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(16'h8000 + $urandom_range(255));
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic push_full_frame();
      for (int p = 0; p < NPIX; p++)
         send(OP_PUSH, p, pick_value(), p == NPIX - 1);
   endtask

   // request with noise in the ignored fields; top up the window first if needed
   task automatic ask_median();
      while (!query_is_safe()) push_full_frame();
      send(OP_MEDIAN, $urandom_range(63), 16'($urandom_range(16'hFFFF)),
         1'($urandom_range(1)));
   endtask

   // fill what the spare slot lacks, overwrite a few pixels, then commit
   task automatic push_partial_frame();
      int spare, cnt;
      spare = (newest + 1) % NSLOT;
      for (int p = 0; p < NPIX; p++)
         if (!filled[spare][p]) send(OP_PUSH, p, pick_value(), 1'b0);
      cnt = $urandom_range(6);
      for (int i = 0; i < cnt; i++)
         send(OP_PUSH, $urandom_range(63), pick_value(), 1'b0);
      send(OP_PUSH, $urandom_range(63), pick_value(), 1'b1);
   endtask

   task automatic test_directed();
      ask_median();                       // empty window at reset length
      csr_write(ADDR_WINDOW_LEN, 32'd0);  // saturates to 1
      csr_check(ADDR_WINDOW_LEN, 32'd1);
      push_full_frame();
      ask_median();
      csr_write(ADDR_UNUSED, 32'd3);      // ignored
      push_full_frame();
      ask_median();                       // oldest frame dropped
      csr_write(ADDR_WINDOW_LEN, 32'd31); // saturates to the maximum
      csr_check(ADDR_WINDOW_LEN, 32'(WMAX));
      ask_median();                       // cleared count: empty again
      csr_write(ADDR_WINDOW_LEN, 32'd2);
      push_full_frame();
      ask_median();
      push_partial_frame();               // spare slot was never written, so all pixels are sent
      ask_median();                       // even count: floor of mean
   endtask

   task automatic test_random(int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9) < 3) ask_median();
         else send(OP_PUSH, $urandom_range(NPIX - 1), pick_value(), 1'b0);
         sent++;
      end
   endtask

   task automatic test_back_pressure();
      hold_len = 3000;
      hold_go = 1'b1;
      ask_median();
      ask_median();                        // blocked behind the held scan
      send(OP_PUSH, $urandom_range(NPIX - 1), pick_value(), 1'b0);
      ask_median();
      drain();                             // pause until every result is in
      quiet = 1'b1;                        // stretch with no idling
      ask_median();
      send(OP_PUSH, $urandom_range(NPIX - 1), pick_value(), 1'b0);
      ask_median();
      drain();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_pressure();
      test_random(96);
      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && medians_due.size() == 0)
         $display("[sliding_window_pixel_median] OK");
      else
         $display("[sliding_window_pixel_median] ERROR");
      $finish;
   end

endmodule

FILE: sliding_window_pixel_median.f
rtl/core/swpm_pkg.sv
rtl/core/swpm_ctrl.sv
rtl/core/swpm_dp.sv
rtl/core/sliding_window_pixel_median.sv
tb/sliding_window_pixel_median_tb.sv
